// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the checker file of the modular exponentiation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("modexp assertion failed");

// Concurrent assertion on the block clock and reset.
`define ASSERT_ON(label, prop) \
    `ASSERT_CLK_RST(label, aclk, aresetn, prop)

`endif

// ----- hw/rtl/modexp_pkg.sv -----
// Package with widths and register codes of the modular exponentiation block.
package modexp_pkg;

    localparam int DATA_BITS            = 64;
    localparam int DEFAULT_OPERAND_BITS = 64;
    localparam int CFG_INDEX_BITS       = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = CFG_INDEX_BITS'(1);

endpackage

// ----- hw/rtl/modexp_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, double-and-add reduction.
module modexp_mulmod import modexp_pkg::*; #(
    parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [OPERAND_BITS-1:0] op_a,
    input  logic [OPERAND_BITS-1:0] op_b,
    input  logic [OPERAND_BITS-1:0] modulus,
    output logic                    done,
    output logic [OPERAND_BITS-1:0] product
);

    localparam int W        = OPERAND_BITS + 2;
    localparam int CNT_BITS = $clog2(OPERAND_BITS);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic [OPERAND_BITS-1:0] acc_reg, acc_next;
    logic [OPERAND_BITS-1:0] a_reg, a_next;
    logic [OPERAND_BITS-1:0] b_reg, b_next;

    logic [W-1:0] sum;
    logic [W-1:0] mod_one;
    logic [W-1:0] mod_two;
    logic [W-1:0] step;

    // The sum 2*acc + a stays below three times the modulus, so at most two
    // subtractions of the modulus bring it back into range.
    always_comb begin
        mod_one = W'(modulus);
        mod_two = {1'b0, modulus, 1'b0};
        sum     = {1'b0, acc_reg, 1'b0} + (b_reg[OPERAND_BITS-1] ? W'(a_reg) : '0);
        if (sum >= mod_two) begin
            step = sum - mod_two;
        end else if (sum >= mod_one) begin
            step = sum - mod_one;
        end else begin
            step = sum;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(OPERAND_BITS - 1);
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
        end else if (busy_reg) begin
            acc_next = step[OPERAND_BITS-1:0];
            b_next   = {b_reg[OPERAND_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- hw/rtl/modular_exponentiation_unit.sv -----
// Modular exponentiation unit: base to a configured exponent, modulo a configured modulus.
// Each item carries one base and yields one residue. The base is first reduced by the
// modulus, then the exponent is scanned from its least significant bit with
// square-and-multiply, all on one bit-serial modular multiplier. An item costs one
// reduction plus one squaring for every exponent bit below the highest set bit and one
// multiplication for every set bit, so at most 2*OPERAND_BITS multiplier passes, one
// multiplier pass for a zero exponent, and none for a modulus below two (which gives a
// residue of zero). The input side is ready only between items; a finished residue
// sits in an output register, so the next item is taken while it waits.
// The user must write configuration through the cfg port (index 0 modulus, 1 exponent)
// only while no item is in flight; the block itself does not enforce it. Bits above
// OPERAND_BITS are ignored.
module modular_exponentiation_unit import modexp_pkg::*; #(
    parameter int OPERAND_BITS = DEFAULT_OPERAND_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]      cfg_data,
    // Input items.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [DATA_BITS-1:0]      s_tdata,   // [63:0] base_value
    // Result items.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [DATA_BITS-1:0]      m_tdata    // [63:0] residue
);

    localparam int N = OPERAND_BITS;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_MUL    = 5'b00100,
        S_SQR    = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic                 start_reg, start_next;
    logic [N-1:0]         mod_reg, mod_next;
    logic [N-1:0]         exp_reg, exp_next;
    logic [N-1:0]         e_reg, e_next;
    logic [N-1:0]         sq_reg, sq_next;
    logic [N-1:0]         acc_reg, acc_next;
    logic [DATA_BITS-1:0] res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;

    logic         mul_done;
    logic [N-1:0] mul_product;
    logic [N-1:0] mul_a;
    logic [N-1:0] mul_b;
    logic [N-1:0] e_shift;

    modexp_mulmod #(
        .OPERAND_BITS(N)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (mod_reg),
        .done    (mul_done),
        .product (mul_product)
    );

    // The reduction of the base is a multiplication of one by the base.
    always_comb begin
        case (state_reg)
            S_REDUCE: begin
                mul_a = N'(1);
                mul_b = sq_reg;
            end
            S_MUL: begin
                mul_a = acc_reg;
                mul_b = sq_reg;
            end
            default: begin
                mul_a = sq_reg;
                mul_b = sq_reg;
            end
        endcase
    end

    assign e_shift = {1'b0, e_reg[N-1:1]};

    always_comb begin
        state_next     = state_reg;
        start_next     = 1'b0;
        mod_next       = mod_reg;
        exp_next       = exp_reg;
        e_next         = e_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            if (cfg_index == REG_MODULUS) begin
                mod_next = cfg_data[N-1:0];
            end else if (cfg_index == REG_EXPONENT) begin
                exp_next = cfg_data[N-1:0];
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    e_next   = exp_reg;
                    sq_next  = s_tdata[N-1:0];
                    acc_next = N'(1);
                    if (mod_reg[N-1:1] == '0) begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_REDUCE;
                        start_next = 1'b1;
                    end
                end
            end
            S_REDUCE: begin
                if (mul_done) begin
                    sq_next = mul_product;
                    if (e_reg[0]) begin
                        state_next = S_MUL;
                        start_next = 1'b1;
                    end else if (e_reg != '0) begin
                        state_next = S_SQR;
                        start_next = 1'b1;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    acc_next = mul_product;
                    if (e_shift != '0) begin
                        state_next = S_SQR;
                        start_next = 1'b1;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SQR: begin
                if (mul_done) begin
                    sq_next = mul_product;
                    e_next  = e_shift;
                    // Only squarings that a higher set bit still needs are issued,
                    // so the shifted exponent is never zero here.
                    if (e_shift[0]) begin
                        state_next = S_MUL;
                    end else begin
                        state_next = S_SQR;
                    end
                    start_next = 1'b1;
                end
            end
            S_FINISH: begin
                if (!out_valid_reg || m_tready) begin
                    res_next       = DATA_BITS'(acc_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            mod_reg       <= N'(2);
            exp_reg       <= N'(1);
        end else begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            mod_reg       <= mod_next;
            exp_reg       <= exp_next;
        end
        e_reg   <= e_next;
        sq_reg  <= sq_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = res_reg;

endmodule

// ----- hw/rtl/modexp_checker.sv -----
// Port-level checker for the modular exponentiation unit, bound to the top level.
`include "assert_macros.svh"

module modexp_checker import modexp_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_BITS-1:0] m_tdata
);

    // A result waiting on the output holds its value.
    `ASSERT_ON(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // The unit leaves the idle state on each accept, so the input closes after each accept.
    `ASSERT_ON(a_in_closes, s_tvalid && s_tready |=> !s_tready)

    // A new result is loaded only at the end of an item, never from the idle state.
    `ASSERT_ON(a_result_after_work, $rose(m_tvalid) |-> $past(!s_tready))

endmodule

bind modular_exponentiation_unit modexp_checker u_modexp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
